// File: src/midpoint_ellipse_rasterizer_top_assert.svh
// Assertion macros used by the ellipse rasterizer sequencer.
// Needs only a clock and an active-high reset in the file that includes it.
`ifndef MIDPOINT_ELLIPSE_RASTERIZER_TOP_ASSERT_SVH
`define MIDPOINT_ELLIPSE_RASTERIZER_TOP_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define MER_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define MER_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: src/mer_pkg.sv
// Shared widths, codes and control structs of the midpoint ellipse rasterizer.
// No dependencies; every other .sv file imports this package.
`timescale 1ns / 1ps

package mer_pkg;

   localparam int RADIUS_BITS    = 10;
   localparam int COORD_BITS     = 12;
   localparam int OFS_BITS       = RADIUS_BITS + 1;
   localparam int SQ_BITS        = 2 * RADIUS_BITS;
   localparam int CMP_BITS       = SQ_BITS + OFS_BITS;
   localparam int DEC_BITS       = 48;
   localparam int PROD_BITS      = (DEC_BITS > CMP_BITS) ? DEC_BITS : CMP_BITS;
   localparam int OUT_BITS       = 14;
   localparam int CSR_INDEX_BITS = 1;
   localparam logic [COORD_BITS-1:0] CENTER_RESET = COORD_BITS'(250);

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_CENTER_X = CSR_INDEX_BITS'(0),
      CSR_CENTER_Y = CSR_INDEX_BITS'(1)
   } csr_index_type;

   typedef enum logic {
      KIND_START = 1'b0,
      KIND_STEP  = 1'b1
   } kind_type;

   typedef enum logic [1:0] {
      ACC_HOLD = 2'd0,
      ACC_LOAD = 2'd1,
      ACC_ADD  = 2'd2,
      ACC_SUB  = 2'd3
   } acc_op_type;

   // Sequencer to multiply-accumulate unit.
   typedef struct packed {
      logic [CMP_BITS-1:0] op_a;
      logic [SQ_BITS-1:0]  op_b;
      acc_op_type          acc_op;
      logic                dbl;
      logic                save_cmp;
   } mac_ctl_type;

   // Multiply-accumulate unit back to the sequencer.
   typedef struct packed {
      logic [PROD_BITS-1:0] prod;
      logic                 dec_neg;
      logic                 dec_zero;
      logic                 holds;
   } mac_status_type;

   // Sequencer to the top level.
   typedef struct packed {
      logic idle;
      logic load;
      logic point_valid;
      logic last;
   } seq_status_type;

endpackage

// File: src/mer_channels.sv
// Handshake interfaces for the request and response channels.
// Depends on mer_pkg for the field widths.
`timescale 1ns / 1ps

interface mer_req_if import mer_pkg::*; ();
   logic                   valid;
   logic                   ready;
   logic                   kind;
   logic [RADIUS_BITS-1:0] radius_x;
   logic [RADIUS_BITS-1:0] radius_y;

   modport source (output valid, kind, radius_x, radius_y, input ready);
   modport sink (input valid, kind, radius_x, radius_y, output ready);
endinterface

interface mer_rsp_if import mer_pkg::*; ();
   logic                       valid;
   logic                       ready;
   logic                       point_valid;
   logic                       last_point;
   logic signed [OUT_BITS-1:0] right_x;
   logic signed [OUT_BITS-1:0] left_x;
   logic signed [OUT_BITS-1:0] upper_y;
   logic signed [OUT_BITS-1:0] lower_y;

   modport source (output valid, point_valid, last_point, right_x, left_x, upper_y, lower_y,
                   input ready);
   modport sink (input valid, point_valid, last_point, right_x, left_x, upper_y, lower_y,
                 output ready);
endinterface

// File: src/mer_mac.sv
// Shared multiplier with registered product, decision accumulator and compare register.
// Depends on mer_pkg.
`timescale 1ns / 1ps

module mer_mac import mer_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  mac_ctl_type    ctl,
   output mac_status_type status
);

   localparam int MUL_BITS  = CMP_BITS + SQ_BITS;
   localparam int WIDE_BITS = (MUL_BITS > PROD_BITS) ? MUL_BITS : PROD_BITS;

   logic [WIDE_BITS-1:0] mul_full;
   logic [PROD_BITS-1:0] prod_ff, prod_in;
   logic [CMP_BITS-1:0]  cmp_ff, cmp_in;
   logic [DEC_BITS-1:0]  dec_ff, dec_in;
   logic [DEC_BITS-1:0]  term;

   assign mul_full = WIDE_BITS'(ctl.op_a) * WIDE_BITS'(ctl.op_b);
   assign prod_in  = mul_full[PROD_BITS-1:0];
   assign cmp_in   = ctl.save_cmp ? prod_ff[CMP_BITS-1:0] : cmp_ff;

   // The accumulator always works on the product of the previous cycle.
   assign term = ctl.dbl ? {prod_ff[DEC_BITS-2:0], 1'b0} : prod_ff[DEC_BITS-1:0];

   always_comb begin
      case (ctl.acc_op)
         ACC_LOAD: dec_in = term;
         ACC_ADD:  dec_in = dec_ff + term;
         ACC_SUB:  dec_in = dec_ff - term;
         default:  dec_in = dec_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
      cmp_ff  <= cmp_in;
      if (reset) begin
         dec_ff <= '0;
      end else begin
         dec_ff <= dec_in;
      end
   end

   assign status.prod     = prod_ff;
   assign status.dec_neg  = dec_ff[DEC_BITS-1];
   assign status.dec_zero = (dec_ff == '0);
   assign status.holds    = (cmp_ff <= prod_ff[CMP_BITS-1:0]);

endmodule

// File: src/mer_seq.sv
// Sequencer of the ellipse walk: holds offsets, squared radii and region, and
// drives the shared multiply-accumulate unit. Depends on mer_pkg and the assert macros.
`timescale 1ns / 1ps
`include "midpoint_ellipse_rasterizer_top_assert.svh"

module mer_seq import mer_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   accept,
   input  logic                   kind,
   input  logic [RADIUS_BITS-1:0] radius_x,
   input  logic [RADIUS_BITS-1:0] radius_y,
   input  logic                   out_free,
   input  mac_status_type         mac_status,
   output mac_ctl_type            mac_ctl,
   output seq_status_type         status,
   output logic [OFS_BITS-1:0]    offset_x,
   output logic [OFS_BITS-1:0]    offset_y
);

   localparam int STATE_BITS = 26;

   typedef enum logic [STATE_BITS-1:0] {
      ST_IDLE   = STATE_BITS'(1) << 0,
      ST_SQ_RX  = STATE_BITS'(1) << 1,
      ST_SQ_RY  = STATE_BITS'(1) << 2,
      ST_S_A2RY = STATE_BITS'(1) << 3,
      ST_S_A2Q  = STATE_BITS'(1) << 4,
      ST_S_DONE = STATE_BITS'(1) << 5,
      ST_CMP0   = STATE_BITS'(1) << 6,
      ST_CMP1   = STATE_BITS'(1) << 7,
      ST_CMP2   = STATE_BITS'(1) << 8,
      ST_T0     = STATE_BITS'(1) << 9,
      ST_T1     = STATE_BITS'(1) << 10,
      ST_T2     = STATE_BITS'(1) << 11,
      ST_T3     = STATE_BITS'(1) << 12,
      ST_I0     = STATE_BITS'(1) << 13,
      ST_I1     = STATE_BITS'(1) << 14,
      ST_I2     = STATE_BITS'(1) << 15,
      ST_I3     = STATE_BITS'(1) << 16,
      ST_I4     = STATE_BITS'(1) << 17,
      ST_I5     = STATE_BITS'(1) << 18,
      ST_I6     = STATE_BITS'(1) << 19,
      ST_I7     = STATE_BITS'(1) << 20,
      ST_U0     = STATE_BITS'(1) << 21,
      ST_U1     = STATE_BITS'(1) << 22,
      ST_U2     = STATE_BITS'(1) << 23,
      ST_U3     = STATE_BITS'(1) << 24,
      ST_EMIT   = STATE_BITS'(1) << 25
   } state_type;

   state_type              state_ff, state_in;
   logic [RADIUS_BITS-1:0] rx_ff, rx_in, ry_ff, ry_in;
   logic [SQ_BITS-1:0]     a2_ff, a2_in, b2_ff, b2_in;
   logic [OFS_BITS-1:0]    x_ff, x_in, y_ff, y_in;
   logic                   region2_ff, region2_in;
   logic                   active_ff, active_in;
   logic                   bump_ff, bump_in;
   logic                   hold_ff, hold_in;
   logic                   idle_item_ff, idle_item_in;
   logic                   last;
   logic                   load;

   assign last = (y_ff == '0) || (region2_ff && hold_ff);

   always_comb begin
      state_in        = state_ff;
      rx_in           = rx_ff;
      ry_in           = ry_ff;
      a2_in           = a2_ff;
      b2_in           = b2_ff;
      x_in            = x_ff;
      y_in            = y_ff;
      region2_in      = region2_ff;
      active_in       = active_ff;
      bump_in         = bump_ff;
      hold_in         = hold_ff;
      idle_item_in    = idle_item_ff;
      load            = 1'b0;
      mac_ctl.op_a    = '0;
      mac_ctl.op_b    = '0;
      mac_ctl.acc_op  = ACC_HOLD;
      mac_ctl.dbl     = 1'b0;
      mac_ctl.save_cmp = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               hold_in      = 1'b0;
               idle_item_in = 1'b0;
               if (kind == KIND_START) begin
                  rx_in    = radius_x;
                  ry_in    = radius_y;
                  state_in = ST_SQ_RX;
               end else if (!active_ff) begin
                  idle_item_in = 1'b1;
                  state_in     = ST_EMIT;
               end else if (region2_ff) begin
                  state_in = ST_U0;
               end else begin
                  state_in = ST_CMP0;
               end
            end
         end
         // Start: a2 = rx*rx, b2 = ry*ry, decision = b2 - a2*ry + a2/4.
         ST_SQ_RX: begin
            mac_ctl.op_a = CMP_BITS'(rx_ff);
            mac_ctl.op_b = SQ_BITS'(rx_ff);
            state_in     = ST_SQ_RY;
         end
         ST_SQ_RY: begin
            a2_in        = mac_status.prod[SQ_BITS-1:0];
            mac_ctl.op_a = CMP_BITS'(ry_ff);
            mac_ctl.op_b = SQ_BITS'(ry_ff);
            state_in     = ST_S_A2RY;
         end
         ST_S_A2RY: begin
            b2_in          = mac_status.prod[SQ_BITS-1:0];
            mac_ctl.acc_op = ACC_LOAD;
            mac_ctl.op_a   = CMP_BITS'(a2_ff);
            mac_ctl.op_b   = SQ_BITS'(ry_ff);
            state_in       = ST_S_A2Q;
         end
         ST_S_A2Q: begin
            mac_ctl.acc_op = ACC_SUB;
            mac_ctl.op_a   = CMP_BITS'(a2_ff >> 2);
            mac_ctl.op_b   = SQ_BITS'(1);
            state_in       = ST_S_DONE;
         end
         ST_S_DONE: begin
            mac_ctl.acc_op = ACC_ADD;
            x_in           = '0;
            y_in           = OFS_BITS'(ry_ff);
            region2_in     = 1'b0;
            state_in       = ST_EMIT;
         end
         // Region test: b2*x against a2*y.
         ST_CMP0: begin
            mac_ctl.op_a = CMP_BITS'(b2_ff);
            mac_ctl.op_b = SQ_BITS'(x_ff);
            state_in     = ST_CMP1;
         end
         ST_CMP1: begin
            mac_ctl.save_cmp = 1'b1;
            mac_ctl.op_a     = CMP_BITS'(a2_ff);
            mac_ctl.op_b     = SQ_BITS'(y_ff);
            state_in         = ST_CMP2;
         end
         ST_CMP2: begin
            if (region2_ff) begin
               // End-of-walk check after a region-two step.
               hold_in  = mac_status.holds;
               state_in = ST_EMIT;
            end else if (mac_status.holds) begin
               x_in = x_ff + OFS_BITS'(1);
               if (!mac_status.dec_neg) begin
                  y_in    = y_ff - OFS_BITS'(1);
                  bump_in = 1'b1;
               end else begin
                  bump_in = 1'b0;
               end
               state_in = ST_T0;
            end else begin
               state_in = ST_I0;
            end
         end
         // Region one: decision += 2*b2*x + b2 (- 2*a2*y when y stepped).
         ST_T0: begin
            mac_ctl.op_a = CMP_BITS'(b2_ff);
            mac_ctl.op_b = SQ_BITS'(x_ff);
            state_in     = ST_T1;
         end
         ST_T1: begin
            mac_ctl.acc_op = ACC_ADD;
            mac_ctl.dbl    = 1'b1;
            mac_ctl.op_a   = CMP_BITS'(b2_ff);
            mac_ctl.op_b   = SQ_BITS'(1);
            state_in       = ST_T2;
         end
         ST_T2: begin
            mac_ctl.acc_op = ACC_ADD;
            if (bump_ff) begin
               mac_ctl.op_a = CMP_BITS'(a2_ff);
               mac_ctl.op_b = SQ_BITS'(y_ff);
               state_in     = ST_T3;
            end else begin
               state_in = ST_EMIT;
            end
         end
         ST_T3: begin
            mac_ctl.acc_op = ACC_SUB;
            mac_ctl.dbl    = 1'b1;
            state_in       = ST_EMIT;
         end
         // Region-two decision from the current offsets.
         ST_I0: begin
            mac_ctl.op_a = CMP_BITS'(b2_ff);
            mac_ctl.op_b = SQ_BITS'(x_ff);
            state_in     = ST_I1;
         end
         ST_I1: begin
            mac_ctl.acc_op = ACC_LOAD;
            mac_ctl.op_a   = mac_status.prod[CMP_BITS-1:0];
            mac_ctl.op_b   = SQ_BITS'(x_ff);
            state_in       = ST_I2;
         end
         ST_I2: begin
            mac_ctl.acc_op = ACC_ADD;
            mac_ctl.op_a   = CMP_BITS'(b2_ff >> 2);
            mac_ctl.op_b   = SQ_BITS'(1);
            state_in       = ST_I3;
         end
         ST_I3: begin
            mac_ctl.acc_op = ACC_ADD;
            mac_ctl.op_a   = CMP_BITS'(a2_ff);
            mac_ctl.op_b   = SQ_BITS'(y_ff);
            state_in       = ST_I4;
         end
         ST_I4: begin
            // The a2*y product serves both the doubled term and the a2*y*y product.
            mac_ctl.acc_op = ACC_SUB;
            mac_ctl.dbl    = 1'b1;
            mac_ctl.op_a   = mac_status.prod[CMP_BITS-1:0];
            mac_ctl.op_b   = SQ_BITS'(y_ff);
            state_in       = ST_I5;
         end
         ST_I5: begin
            mac_ctl.acc_op = ACC_ADD;
            mac_ctl.op_a   = CMP_BITS'(a2_ff);
            mac_ctl.op_b   = SQ_BITS'(1);
            state_in       = ST_I6;
         end
         ST_I6: begin
            mac_ctl.acc_op = ACC_ADD;
            mac_ctl.op_a   = CMP_BITS'(a2_ff);
            mac_ctl.op_b   = b2_ff;
            state_in       = ST_I7;
         end
         ST_I7: begin
            mac_ctl.acc_op = ACC_SUB;
            region2_in     = 1'b1;
            state_in       = ST_U0;
         end
         // Region two: decision += a2 - 2*a2*y (+ 2*b2*x when x stepped).
         ST_U0: begin
            y_in = y_ff - OFS_BITS'(1);
            if (mac_status.dec_neg || mac_status.dec_zero) begin
               x_in    = x_ff + OFS_BITS'(1);
               bump_in = 1'b1;
            end else begin
               bump_in = 1'b0;
            end
            mac_ctl.op_a = CMP_BITS'(a2_ff);
            mac_ctl.op_b = SQ_BITS'(1);
            state_in     = ST_U1;
         end
         ST_U1: begin
            mac_ctl.acc_op = ACC_ADD;
            mac_ctl.op_a   = CMP_BITS'(a2_ff);
            mac_ctl.op_b   = SQ_BITS'(y_ff);
            state_in       = ST_U2;
         end
         ST_U2: begin
            mac_ctl.acc_op = ACC_SUB;
            mac_ctl.dbl    = 1'b1;
            if (bump_ff) begin
               mac_ctl.op_a = CMP_BITS'(b2_ff);
               mac_ctl.op_b = SQ_BITS'(x_ff);
               state_in     = ST_U3;
            end else begin
               state_in = ST_CMP0;
            end
         end
         ST_U3: begin
            mac_ctl.acc_op = ACC_ADD;
            mac_ctl.dbl    = 1'b1;
            state_in       = ST_CMP0;
         end
         ST_EMIT: begin
            if (out_free) begin
               load = 1'b1;
               if (!idle_item_ff) begin
                  active_in = !last;
               end
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      rx_ff <= rx_in;
      ry_ff <= ry_in;
      a2_ff <= a2_in;
      b2_ff <= b2_in;
      bump_ff <= bump_in;
      if (reset) begin
         state_ff     <= ST_IDLE;
         x_ff         <= '0;
         y_ff         <= '0;
         region2_ff   <= 1'b0;
         active_ff    <= 1'b0;
         hold_ff      <= 1'b0;
         idle_item_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         x_ff         <= x_in;
         y_ff         <= y_in;
         region2_ff   <= region2_in;
         active_ff    <= active_in;
         hold_ff      <= hold_in;
         idle_item_ff <= idle_item_in;
      end
   end

   assign status.idle        = (state_ff == ST_IDLE);
   assign status.load        = load;
   assign status.point_valid = !idle_item_ff;
   assign status.last        = !idle_item_ff && last;
   assign offset_x           = x_ff;
   assign offset_y           = y_ff;

   `MER_ASSERT_NEXT(a_start_seq, clock, reset,
      state_ff == ST_IDLE && accept && kind == KIND_START, state_ff == ST_SQ_RX,
      "start word did not enter the squaring sequence")
   `MER_ASSERT_NEXT(a_last_deactivates, clock, reset,
      load && status.point_valid && status.last, !active_ff,
      "ellipse still active after its last point set")
   `MER_ASSERT_NOW(a_region2_y_nonzero, clock, reset,
      state_ff == ST_U0, y_ff != '0,
      "region-two step started with zero y offset")
   `MER_ASSERT_NOW(a_region2_check_origin, clock, reset,
      state_ff == ST_CMP0 && region2_ff,
      $past(state_ff) == ST_U2 || $past(state_ff) == ST_U3,
      "region-two end check entered without a region-two step")

endmodule

// File: src/midpoint_ellipse_rasterizer_top.sv
// Top level of the midpoint ellipse rasterizer: center registers, response register
// and coordinate adders. Depends on mer_pkg, mer_channels, mer_mac and mer_seq.
//
//   channel   direction  handshake     payload
//   req_bus   in         valid/ready   kind, radius_x, radius_y
//   rsp_bus   out        valid/ready   point_valid, last_point, right_x, left_x,
//                                      upper_y, lower_y
//   csr_*     in         csr_wr_en     csr_index, csr_wr_data (center_x, center_y)
//
// A start word squares the radii and loads the decision; a step runs the region test and
// the decision update, rebuilding it on entry to region two; a step while idle goes out.
// All work runs on the single shared multiplier, one product per cycle under the sequencer.
// req_bus.ready is high only while the sequencer is idle. Synchronous reset clears the
// walk state and loads 250 into both center registers. A stalled response holds the
// finished word in the sequencer until the response register frees up.
`timescale 1ns / 1ps

module midpoint_ellipse_rasterizer_top import mer_pkg::*; (
   input  logic                      clock,
   input  logic                      reset,
   mer_req_if.sink                   req_bus,
   mer_rsp_if.source                 rsp_bus,
   input  logic                      csr_wr_en,
   input  logic [CSR_INDEX_BITS-1:0] csr_index,
   input  logic [COORD_BITS-1:0]     csr_wr_data
);

   logic [COORD_BITS-1:0] center_x_ff, center_y_ff;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic                  point_valid_ff, last_ff;
   logic [OUT_BITS-1:0]   right_x_ff, left_x_ff, upper_y_ff, lower_y_ff;
   logic [OUT_BITS-1:0]   right_x_in, left_x_in, upper_y_in, lower_y_in;
   logic [OFS_BITS-1:0]   offset_x, offset_y;
   logic                  req_accept;
   logic                  out_free;
   mac_ctl_type           mac_ctl;
   mac_status_type        mac_status;
   seq_status_type        seq_status;

   assign req_bus.ready = seq_status.idle;
   assign req_accept    = req_bus.valid && seq_status.idle;
   assign out_free      = !rsp_valid_ff || rsp_bus.ready;

   mer_mac u_mac (
      .clock  (clock),
      .reset  (reset),
      .ctl    (mac_ctl),
      .status (mac_status)
   );

   mer_seq u_seq (
      .clock      (clock),
      .reset      (reset),
      .accept     (req_accept),
      .kind       (req_bus.kind),
      .radius_x   (req_bus.radius_x),
      .radius_y   (req_bus.radius_y),
      .out_free   (out_free),
      .mac_status (mac_status),
      .mac_ctl    (mac_ctl),
      .status     (seq_status),
      .offset_x   (offset_x),
      .offset_y   (offset_y)
   );

   // Coordinates wrap to the output width, as two's complement.
   always_comb begin
      if (seq_status.point_valid) begin
         right_x_in = OUT_BITS'(center_x_ff) + OUT_BITS'(offset_x);
         left_x_in  = OUT_BITS'(center_x_ff) - OUT_BITS'(offset_x);
         upper_y_in = OUT_BITS'(center_y_ff) + OUT_BITS'(offset_y);
         lower_y_in = OUT_BITS'(center_y_ff) - OUT_BITS'(offset_y);
      end else begin
         right_x_in = '0;
         left_x_in  = '0;
         upper_y_in = '0;
         lower_y_in = '0;
      end
   end

   assign rsp_valid_in = seq_status.load ? 1'b1 : (rsp_bus.ready ? 1'b0 : rsp_valid_ff);

   always_ff @(posedge clock) begin
      if (seq_status.load) begin
         point_valid_ff <= seq_status.point_valid;
         last_ff        <= seq_status.last;
         right_x_ff     <= right_x_in;
         left_x_ff      <= left_x_in;
         upper_y_ff     <= upper_y_in;
         lower_y_ff     <= lower_y_in;
      end
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         center_x_ff  <= CENTER_RESET;
         center_y_ff  <= CENTER_RESET;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wr_en) begin
            unique case (csr_index_type'(csr_index))
               CSR_CENTER_X: center_x_ff <= csr_wr_data;
               CSR_CENTER_Y: center_y_ff <= csr_wr_data;
               default: ;
            endcase
         end
      end
   end

   assign rsp_bus.valid       = rsp_valid_ff;
   assign rsp_bus.point_valid = point_valid_ff;
   assign rsp_bus.last_point  = last_ff;
   assign rsp_bus.right_x     = right_x_ff;
   assign rsp_bus.left_x      = left_x_ff;
   assign rsp_bus.upper_y     = upper_y_ff;
   assign rsp_bus.lower_y     = lower_y_ff;

endmodule

// File: dv/testbench.sv
// Self-checking testbench for midpoint_ellipse_rasterizer_top: directed words, then random
// ellipse walks under several center settings. Depends on mer_pkg and mer_channels.
`timescale 1ns / 1ps

module testbench;
   import mer_pkg::*;

   localparam int TOTAL_WORDS = 1550;
   localparam int PHASES      = 6;
   localparam int QUIET_LIMIT = 2000;

   typedef struct packed {
      logic                       point_valid;
      logic                       last_point;
      logic signed [OUT_BITS-1:0] right_x;
      logic signed [OUT_BITS-1:0] left_x;
      logic signed [OUT_BITS-1:0] upper_y;
      logic signed [OUT_BITS-1:0] lower_y;
   } point_set_type;

   // Tracks the walk state of the rasterizer and holds the point sets it still owes.
   class ellipse_point_scoreboard;
      logic [COORD_BITS-1:0] center_x;
      logic [COORD_BITS-1:0] center_y;
      logic [OFS_BITS-1:0]   ofs_x;
      logic [OFS_BITS-1:0]   ofs_y;
      logic [DEC_BITS-1:0]   decision;
      logic                  in_region_two;
      bit                    walking;
      logic [SQ_BITS-1:0]    rx_sq;
      logic [SQ_BITS-1:0]    ry_sq;
      point_set_type         expected_points[$];
      int                    mismatches;

      function new();
         center_x      = CENTER_RESET;
         center_y      = CENTER_RESET;
         ofs_x         = '0;
         ofs_y         = '0;
         decision      = '0;
         in_region_two = 1'b0;
         walking       = 1'b0;
         rx_sq         = '0;
         ry_sq         = '0;
         mismatches    = 0;
      endfunction

      function void set_center(logic [COORD_BITS-1:0] cx, logic [COORD_BITS-1:0] cy);
         center_x = cx;
         center_y = cy;
      endfunction

      function int pending();
         return expected_points.size();
      endfunction

      // True while the walk is still on the flat part of the curve, where b2*x <= a2*y.
      function bit slope_below();
         return (64'(ry_sq) * 64'(ofs_x)) <= (64'(rx_sq) * 64'(ofs_y));
      endfunction

      function point_set_type point_at(bit last);
         point_set_type p;
         p.point_valid = 1'b1;
         p.last_point  = last;
         p.right_x     = OUT_BITS'(center_x) + OUT_BITS'(ofs_x);
         p.left_x      = OUT_BITS'(center_x) - OUT_BITS'(ofs_x);
         p.upper_y     = OUT_BITS'(center_y) + OUT_BITS'(ofs_y);
         p.lower_y     = OUT_BITS'(center_y) - OUT_BITS'(ofs_y);
         return p;
      endfunction

      // Advances the walk by one accepted request word and queues the point set it yields.
      function void note_request(kind_type kind, logic [RADIUS_BITS-1:0] rx,
                                 logic [RADIUS_BITS-1:0] ry);
         logic [63:0]   a2, b2, x, y, acc;
         bit            last;
         point_set_type p;
         if (kind == KIND_START) begin
            rx_sq         = SQ_BITS'(rx) * SQ_BITS'(rx);
            ry_sq         = SQ_BITS'(ry) * SQ_BITS'(ry);
            ofs_x         = '0;
            ofs_y         = OFS_BITS'(ry);
            in_region_two = 1'b0;
            a2            = 64'(rx_sq);
            b2            = 64'(ry_sq);
            acc           = b2 - a2 * 64'(ry) + (a2 >> 2);
            decision      = DEC_BITS'(acc);
            last          = (ofs_y == '0);
            walking       = !last;
            p             = point_at(last);
         end else if (!walking) begin
            p = '0;
         end else begin
            a2 = 64'(rx_sq);
            b2 = 64'(ry_sq);
            if (!in_region_two && slope_below()) begin
               ofs_x = ofs_x + 1'b1;
               if (!decision[DEC_BITS-1]) begin
                  ofs_y = ofs_y - 1'b1;
                  acc = 64'(decision) + 2 * b2 * 64'(ofs_x) + b2 - 2 * a2 * 64'(ofs_y);
               end else begin
                  acc = 64'(decision) + 2 * b2 * 64'(ofs_x) + b2;
               end
               decision = DEC_BITS'(acc);
            end else begin
               if (!in_region_two) begin
                  // The decision is rebuilt from the current offsets on entry to region two.
                  x             = 64'(ofs_x);
                  y             = 64'(ofs_y);
                  in_region_two = 1'b1;
                  acc = b2 * x * x + (b2 >> 2) + b2 * x + a2 * y * y + a2 - 2 * a2 * y
                        - a2 * b2;
                  decision = DEC_BITS'(acc);
               end
               ofs_y = ofs_y - 1'b1;
               if (decision[DEC_BITS-1] || decision == '0) begin
                  ofs_x = ofs_x + 1'b1;
                  acc = 64'(decision) + 2 * b2 * 64'(ofs_x) + a2 - 2 * a2 * 64'(ofs_y);
               end else begin
                  acc = 64'(decision) + a2 - 2 * a2 * 64'(ofs_y);
               end
               decision = DEC_BITS'(acc);
            end
            last = (ofs_y == '0) || (in_region_two && slope_below());
            if (last) walking = 1'b0;
            p = point_at(last);
         end
         expected_points.push_back(p);
      endfunction

      function void flag(string what, point_set_type want, point_set_type got);
         mismatches++;
         if (mismatches <= 10) begin
            $display("%0t: %s: expected valid=%0b last=%0b x=%0d/%0d y=%0d/%0d", $time, what,
                     want.point_valid, want.last_point, want.right_x, want.left_x,
                     want.upper_y, want.lower_y);
            $display("%0t: %s: actual   valid=%0b last=%0b x=%0d/%0d y=%0d/%0d", $time, what,
                     got.point_valid, got.last_point, got.right_x, got.left_x,
                     got.upper_y, got.lower_y);
         end
      endfunction

      function void check_response(point_set_type got);
         point_set_type want;
         if (expected_points.size() == 0) begin
            flag("unexpected point set", '0, got);
            return;
         end
         want = expected_points.pop_front();
         if (got.point_valid !== want.point_valid || got.last_point !== want.last_point ||
             got.right_x !== want.right_x || got.left_x !== want.left_x ||
             got.upper_y !== want.upper_y || got.lower_y !== want.lower_y)
            flag("point set mismatch", want, got);
      endfunction
   endclass

   logic                      clock = 1'b0;
   logic                      reset;
   logic                      csr_wr_en;
   logic [CSR_INDEX_BITS-1:0] csr_index;
   logic [COORD_BITS-1:0]     csr_wr_data;

   mer_req_if req_bus ();
   mer_rsp_if rsp_bus ();

   midpoint_ellipse_rasterizer_top u_top (
      .clock       (clock),
      .reset       (reset),
      .req_bus     (req_bus),
      .rsp_bus     (rsp_bus),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data)
   );

   ellipse_point_scoreboard tracker;
   int                      words_sent;
   int                      burst_left;
   bit                      gaps_on;
   bit                      req_up;
   int                      quiet_cycles;

   always #4 clock = ~clock;

   // Offers one request word and holds it until it is taken; a burst may end in a gap.
   task automatic send_word(kind_type kind, logic [RADIUS_BITS-1:0] rx,
                            logic [RADIUS_BITS-1:0] ry);
      int unsigned gap;
      req_bus.valid    <= 1'b1;
      req_bus.kind     <= kind;
      req_bus.radius_x <= rx;
      req_bus.radius_y <= ry;
      req_up = 1'b1;
      do @(posedge clock); while (!(req_bus.valid && req_bus.ready));
      tracker.note_request(kind, rx, ry);
      words_sent++;
      gap = 0;
      if (burst_left > 0) burst_left--;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 24);
         if (gaps_on) gap = $urandom_range(1, 24);
      end
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         req_up = 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // The radius fields of a step word are ignored, so they carry random bits.
   task automatic step_word();
      send_word(KIND_STEP, RADIUS_BITS'($urandom), RADIUS_BITS'($urandom));
   endtask

   // Holds the request side quiet until every owed point set has come back.
   task automatic drain();
      if (req_up) begin
         req_bus.valid <= 1'b0;
         req_up = 1'b0;
      end
      while (tracker.pending() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   initial begin : stimulus
      int                      ph, phase_end, pick, cap, n;
      logic [RADIUS_BITS-1:0]  rx, ry;
      logic [COORD_BITS-1:0]   cx, cy;
      reset            = 1'b1;
      req_bus.valid    = 1'b0;
      req_bus.kind     = KIND_START;
      req_bus.radius_x = '0;
      req_bus.radius_y = '0;
      csr_wr_en        = 1'b0;
      csr_index        = CSR_CENTER_X;
      csr_wr_data      = '0;
      req_up           = 1'b0;
      gaps_on          = 1'b1;
      burst_left       = 0;
      words_sent       = 0;
      tracker          = new();
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed words with the centers at their reset values.
      step_word();
      send_word(KIND_START, 10'd0, 10'd0);
      step_word();
      send_word(KIND_START, 10'd1023, 10'd1023);
      repeat (2) step_word();
      // A new start drops the running ellipse; a zero vertical radius ends it at once.
      send_word(KIND_START, 10'd1023, 10'd0);
      send_word(KIND_START, 10'd0, 10'd3);
      while (tracker.walking) step_word();
      send_word(KIND_START, 10'd3, 10'd2);
      while (tracker.walking) step_word();
      step_word();
      send_word(KIND_START, 10'd1, 10'd1023);
      repeat (2) step_word();
      send_word(KIND_START, 10'h2AA, 10'h155);
      step_word();
      send_word(KIND_START, 10'h155, 10'h2AA);
      step_word();

      for (ph = 0; ph < PHASES; ph++) begin
         drain();
         case (ph)
            0: begin cx = '0; cy = '0; end
            1: begin cx = '1; cy = '1; end
            3: begin cx = '0; cy = '1; end
            4: begin cx = '1; cy = '0; end
            default: begin cx = COORD_BITS'($urandom); cy = COORD_BITS'($urandom); end
         endcase
         csr_wr_en   <= 1'b1;
         csr_index   <= CSR_CENTER_X;
         csr_wr_data <= cx;
         @(posedge clock);
         csr_index   <= CSR_CENTER_Y;
         csr_wr_data <= cy;
         @(posedge clock);
         csr_wr_en   <= 1'b0;
         tracker.set_center(cx, cy);

         // One phase sends back to back with no gaps at all.
         gaps_on   = (ph != 2);
         phase_end = words_sent + (TOTAL_WORDS - words_sent) / (PHASES - ph);
         while (words_sent < phase_end) begin
            // Mostly small ellipses walked to the end; large radii are cut short.
            pick = $urandom_range(0, 99);
            if (pick < 65) begin
               rx  = RADIUS_BITS'($urandom_range(0, 12));
               ry  = RADIUS_BITS'($urandom_range(0, 12));
               cap = 1000;
            end else if (pick < 85) begin
               rx  = RADIUS_BITS'($urandom_range(1, 60));
               ry  = RADIUS_BITS'($urandom_range(1, 60));
               cap = (pick < 75) ? 1000 : $urandom_range(1, 40);
            end else begin
               rx  = RADIUS_BITS'($urandom);
               ry  = RADIUS_BITS'($urandom);
               cap = $urandom_range(1, 30);
            end
            send_word(KIND_START, rx, ry);
            n = 0;
            while (tracker.walking && n < cap) begin
               step_word();
               n++;
            end
            if ($urandom_range(0, 9) == 0) repeat ($urandom_range(1, 3)) step_word();
         end
      end

      drain();
      repeat (30) @(posedge clock);
      if (tracker.mismatches == 0 && tracker.pending() == 0)
         $display("PASS midpoint_ellipse_rasterizer_top");
      else
         $display("FAIL midpoint_ellipse_rasterizer_top");
      $finish;
   end

   // Response pacing: random modes, plus two long hold-offs that back the block up.
   initial begin : rsp_pacing
      int cyc, mode, span;
      cyc           = 0;
      span          = 0;
      mode          = 0;
      rsp_bus.ready = 1'b0;
      forever begin
         @(posedge clock);
         cyc++;
         if (cyc == 2500 || cyc == 9000) begin
            rsp_bus.ready <= 1'b0;
            repeat (400) @(posedge clock);
            cyc += 400;
         end else begin
            if (span == 0) begin
               mode = $urandom_range(0, 3);
               span = $urandom_range(16, 200);
            end
            span--;
            case (mode)
               0: rsp_bus.ready <= 1'b1;
               1: rsp_bus.ready <= 1'($urandom_range(0, 1));
               2: rsp_bus.ready <= ($urandom_range(0, 3) == 0);
               default: rsp_bus.ready <= ((cyc / 8) % 2 == 0);
            endcase
         end
      end
   end

   always @(posedge clock) begin : rsp_check
      point_set_type got;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         got.point_valid = rsp_bus.point_valid;
         got.last_point  = rsp_bus.last_point;
         got.right_x     = rsp_bus.right_x;
         got.left_x      = rsp_bus.left_x;
         got.upper_y     = rsp_bus.upper_y;
         got.lower_y     = rsp_bus.lower_y;
         tracker.check_response(got);
      end
   end

   always @(posedge clock) begin : watchdog
      if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("FAIL midpoint_ellipse_rasterizer_top");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

endmodule

// File: midpoint_ellipse_rasterizer_top.f
+incdir+src
src/mer_pkg.sv
src/mer_channels.sv
src/mer_mac.sv
src/mer_seq.sv
src/midpoint_ellipse_rasterizer_top.sv
dv/testbench.sv
